/* rtl/tcw_pkg.sv */
// Shared types, codes and constants for the text console writer.
`default_nettype none

package tcw_pkg;

    localparam int DEF_ROWS      = 25;
    localparam int DEF_COLS      = 80;
    localparam int DEF_TAB_WIDTH = 4;

    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int INDEX_W = 11;
    localparam int CELL_W  = 16;
    localparam int FUNC_W  = 2;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;

    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] TAB_CODE     = 8'd9;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'd7;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_MOVE,
        ST_BLANK,
        ST_RUN,
        ST_CLEAR,
        ST_RESULT
    } tcw_state_t;

    typedef struct packed {
        logic load;
        logic setup_run;
        logic scroll_start;
        logic move_step;
        logic fill_step;
        logic fill_init;
        logic run_step;
        logic read_issue;
        logic out_load;
    } tcw_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              need_scroll;
        logic              move_last;
        logic              fill_last;
        logic              run_done;
        logic              out_full;
    } tcw_sts_t;

endpackage

`default_nettype wire

/* rtl/tcw_ctrl.sv */
// Controller state machine for the text console writer.
`default_nettype none

module tcw_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic             m_tready,
    input  wire tcw_pkg::tcw_sts_t sts,
    output tcw_pkg::tcw_cmd_t     cmd
);
    import tcw_pkg::*;

    tcw_state_t state_reg;
    tcw_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.fill_step = 1'b1;
                cmd.fill_init = 1'b1;
                if (sts.fill_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (sts.func)
                    FUNC_WRITE:
                    begin
                        cmd.setup_run = 1'b1;
                        if (sts.need_scroll)
                        begin
                            cmd.scroll_start = 1'b1;
                            state_next       = ST_MOVE;
                        end
                        else
                        begin
                            state_next = ST_RUN;
                        end
                    end
                    FUNC_READ:
                    begin
                        cmd.read_issue = 1'b1;
                        state_next     = ST_RESULT;
                    end
                    FUNC_CLEAR:
                    begin
                        state_next = ST_CLEAR;
                    end
                    default:
                    begin
                        state_next = ST_RESULT;
                    end
                endcase
            end
            ST_MOVE:
            begin
                cmd.move_step = 1'b1;
                if (sts.move_last)
                begin
                    state_next = ST_BLANK;
                end
            end
            ST_BLANK:
            begin
                cmd.fill_step = 1'b1;
                if (sts.fill_last)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (sts.run_done)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.run_step = 1'b1;
                end
            end
            ST_CLEAR:
            begin
                cmd.fill_step = 1'b1;
                if (sts.fill_last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!sts.out_full || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/tcw_datapath.sv */
// Datapath of the text console writer: cell memory, cursor and output register.
`default_nettype none

module tcw_datapath
#(
    parameter int ROWS      = tcw_pkg::DEF_ROWS,
    parameter int COLS      = tcw_pkg::DEF_COLS,
    parameter int TAB_WIDTH = tcw_pkg::DEF_TAB_WIDTH
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [tcw_pkg::IN_DATA_W-1:0] s_tdata,
    input  wire logic [tcw_pkg::FUNC_W-1:0]    s_tuser,
    input  wire logic                          m_tready,
    output logic                               m_tvalid,
    output logic [tcw_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  wire logic                          cfg_we,
    input  wire logic [tcw_pkg::ATTR_W-1:0]    cfg_wdata,
    input  wire tcw_pkg::tcw_cmd_t             cmd,
    output tcw_pkg::tcw_sts_t                  sts
);
    import tcw_pkg::*;

    localparam int CELLS   = ROWS * COLS;
    localparam int AW      = $clog2(CELLS);
    localparam int CLW     = $clog2(COLS);
    localparam int TBW     = $clog2(TAB_WIDTH + 1);
    localparam int CNT_MAX = (COLS > TAB_WIDTH) ? COLS : TAB_WIDTH;
    localparam int CW      = $clog2(CNT_MAX + 1);

    logic [CELL_W-1:0] mem [CELLS];

    logic [FUNC_W-1:0]  func_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [ATTR_W-1:0]  attr_reg;
    logic [INDEX_W-1:0] idx_reg;
    logic               rd_ok_reg;
    logic               scrolled_reg;
    logic [CW-1:0]      count_reg;
    logic [CELL_W-1:0]  rd_data_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic               m_tvalid_reg;
    logic [AW-1:0]      cursor_reg;
    logic [CLW-1:0]     col_reg;
    logic [TBW-1:0]     tab_reg;
    logic [AW-1:0]      addr_reg;
    logic [ATTR_W-1:0]  blank_attr_reg;

    logic               is_nl;
    logic               is_tab;
    logic [CW-1:0]      run_count;
    logic [AW:0]        reach;
    logic [CELL_W-1:0]  blank_word;
    logic [CELL_W-1:0]  run_word;
    logic [CELL_W-1:0]  fill_word;
    logic [CELL_W-1:0]  read_value;
    logic               move_last;
    logic               fill_last;
    logic               mem_we;
    logic               mem_re;
    logic [AW-1:0]      mem_wa;
    logic [AW-1:0]      mem_ra;
    logic [CELL_W-1:0]  mem_wd;

    assign is_nl  = (char_reg == NEWLINE_CODE);
    assign is_tab = (char_reg == TAB_CODE);

    always_comb
    begin
        if (is_nl)
        begin
            run_count = CW'(COLS) - CW'(col_reg);
        end
        else if (is_tab)
        begin
            run_count = CW'(TAB_WIDTH) - CW'(tab_reg);
        end
        else
        begin
            run_count = CW'(1);
        end
    end

    // A write that would reach the last cell scrolls first, unless the cursor is on the top row.
    assign reach      = {1'b0, cursor_reg} + (AW + 1)'(run_count);
    assign blank_word = {blank_attr_reg, SPACE_CODE};
    assign run_word   = (is_nl || is_tab) ? blank_word : {attr_reg, char_reg};
    assign fill_word  = cmd.fill_init ? {RESET_ATTR, SPACE_CODE} : blank_word;
    assign move_last  = (addr_reg == AW'(CELLS - COLS));
    assign fill_last  = (addr_reg == AW'(CELLS - 1));

    assign sts.func        = func_reg;
    assign sts.need_scroll = (reach >= (AW + 1)'(CELLS)) && (cursor_reg >= AW'(COLS));
    assign sts.move_last   = move_last;
    assign sts.fill_last   = fill_last;
    assign sts.run_done    = (count_reg == '0) || (cursor_reg == AW'(CELLS - 1));
    assign sts.out_full    = m_tvalid_reg;

    // The row move reads one row ahead and writes the word read in the cycle before.
    always_comb
    begin
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_wa = addr_reg;
        mem_wd = fill_word;
        mem_ra = AW'(idx_reg);
        if (cmd.fill_step)
        begin
            mem_we = 1'b1;
        end
        if (cmd.move_step)
        begin
            mem_we = (addr_reg != '0);
            mem_wa = addr_reg - AW'(1);
            mem_wd = rd_data_reg;
            mem_re = !move_last;
            mem_ra = addr_reg + AW'(COLS);
        end
        if (cmd.run_step)
        begin
            mem_we = 1'b1;
            mem_wa = cursor_reg;
            mem_wd = run_word;
        end
        if (cmd.read_issue)
        begin
            mem_re = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    assign read_value = rd_ok_reg ? rd_data_reg : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg     <= s_tuser;
            char_reg     <= s_tdata[CHAR_W-1:0];
            attr_reg     <= s_tdata[CHAR_W +: ATTR_W];
            idx_reg      <= s_tdata[CHAR_W + ATTR_W +: INDEX_W];
            rd_ok_reg    <= (s_tuser == FUNC_READ) &&
                            (32'(s_tdata[CHAR_W + ATTR_W +: INDEX_W]) < CELLS);
            scrolled_reg <= 1'b0;
        end
        if (cmd.scroll_start)
        begin
            scrolled_reg <= 1'b1;
        end
        if (cmd.setup_run)
        begin
            count_reg <= run_count;
        end
        else if (cmd.run_step)
        begin
            count_reg <= count_reg - CW'(1);
        end
        if (cmd.out_load)
        begin
            m_tdata_reg <= {4'b0000, scrolled_reg, INDEX_W'(cursor_reg), read_value};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg     <= '0;
            col_reg        <= '0;
            tab_reg        <= '0;
            addr_reg       <= '0;
            blank_attr_reg <= RESET_ATTR;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                blank_attr_reg <= cfg_wdata;
            end
            if (cmd.scroll_start)
            begin
                cursor_reg <= cursor_reg - AW'(COLS);
            end
            else if (cmd.run_step)
            begin
                cursor_reg <= cursor_reg + AW'(1);
                if (col_reg == CLW'(COLS - 1))
                begin
                    col_reg <= '0;
                    tab_reg <= '0;
                end
                else
                begin
                    col_reg <= col_reg + CLW'(1);
                    tab_reg <= (tab_reg == TBW'(TAB_WIDTH - 1)) ? '0 : tab_reg + TBW'(1);
                end
            end
            // The sweep address parks at zero between sweeps; the row move hands over
            // to the bottom-row blanking at its last source row.
            if (cmd.fill_step)
            begin
                addr_reg <= fill_last ? '0 : addr_reg + AW'(1);
            end
            else if (cmd.move_step)
            begin
                addr_reg <= move_last ? addr_reg : addr_reg + AW'(1);
            end
            if (cmd.out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

/* rtl/text_console_writer.sv */
// Text console writer: ROWS x COLS character cell store with a linear cursor.
// A write stores one cell for a printed character, at most COLS cells for a newline and at most
// TAB_WIDTH cells for a tab; a scroll first moves the rows up and blanks the bottom row, and a
// clear blanks all ROWS*COLS cells. The next beat is taken in the cycle after the result is
// loaded, and a result waits while the previous result beat is stalled. After reset the block
// blanks all ROWS*COLS cells, one per cycle, before it takes an item; configuration writes are
// taken throughout.
`default_nettype none

module text_console_writer
#(
    parameter int ROWS      = tcw_pkg::DEF_ROWS,
    parameter int COLS      = tcw_pkg::DEF_COLS,
    parameter int TAB_WIDTH = tcw_pkg::DEF_TAB_WIDTH
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // char_code [7:0], attr [15:8], cell_index [26:16], zero [31:27]
    input  wire logic [tcw_pkg::IN_DATA_W-1:0]  s_tdata,
    // func [1:0]
    input  wire logic [tcw_pkg::FUNC_W-1:0]     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // read_value [15:0], cursor_pos [26:16], scrolled [27], zero [31:28]
    output logic [tcw_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  wire logic                           cfg_we,
    input  wire logic [tcw_pkg::ATTR_W-1:0]     cfg_wdata
);
    import tcw_pkg::*;

    tcw_cmd_t cmd;
    tcw_sts_t sts;

    tcw_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tcw_datapath
    #(
        .ROWS      (ROWS),
        .COLS      (COLS),
        .TAB_WIDTH (TAB_WIDTH)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

/* rtl/tcw_checker.sv */
// Port-level checks for the text console writer and their bind to the top level.
`default_nettype none

module tcw_port_checks
#(
    parameter int ROWS = tcw_pkg::DEF_ROWS,
    parameter int COLS = tcw_pkg::DEF_COLS
)
(
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [tcw_pkg::OUT_DATA_W-1:0] m_tdata
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLS;

    // Only a write item scrolls, and a write never returns cell data.
    scrolled_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[INDEX_W + CELL_W]) |-> (m_tdata[CELL_W-1:0] == '0))
        else $error("scrolled result carries read data");

    // The cursor always stays on the screen.
    cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((CELLS > 2047) || (32'(m_tdata[CELL_W +: INDEX_W]) < CELLS)))
        else $error("cursor beyond the last cell");

    // One item is in work at a time: an accepted beat closes the input.
    one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted while one is in work");

    stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result beat changed");

endmodule

bind text_console_writer tcw_port_checks
#(
    .ROWS (ROWS),
    .COLS (COLS)
)
u_tcw_port_checks
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
